>>> design/battery_charge_gauge_assert.svh
// assertion macros shared by the battery charge gauge modules
`ifndef BATTERY_CHARGE_GAUGE_ASSERT_SVH
`define BATTERY_CHARGE_GAUGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clock edge outside reset
`define BCG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BCG_ASSERT_NOW(label, ante, cons, msg)
`define BCG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/bcg_pkg.sv
// types, constants and the discharge curve of the battery charge gauge
`timescale 1ns / 1ps
package bcg_pkg;

	// measurement and arithmetic widths
	localparam int VOLTAGE_BITS = 16;
	localparam int CURVE_POINTS = 21;
	localparam int IDX_W        = 5;
	localparam int MV_W         = 13;
	localparam int CMP_W        = (VOLTAGE_BITS > MV_W) ? VOLTAGE_BITS : MV_W;
	localparam int SPAN_W       = 9;
	localparam int NUMER_W      = 11;
	localparam int FRAC_W       = 3;
	localparam int PCT_W        = 7;
	localparam int CHARGE_W     = 8;
	localparam int CELLS_W      = 4;
	localparam int THR_W        = 7;
	localparam int DIV_CNT_W    = $clog2(VOLTAGE_BITS);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 3'd4;

	localparam logic [THR_W-1:0] RST_LOW_THRESHOLD  = 7'd20;
	localparam logic [THR_W-1:0] RST_CRIT_THRESHOLD = 7'd10;
	localparam logic [THR_W-1:0] RST_HYSTERESIS     = 7'd5;

	// charge codes
	localparam logic [CHARGE_W-1:0] CHARGE_UNKNOWN = 8'hFF;
	localparam logic [PCT_W-1:0]    PCT_FULL       = 7'd100;
	localparam logic [PCT_W-1:0]    PCT_EMPTY      = 7'd0;

	// configuration register file contents
	typedef struct packed {
		logic                   battery_enabled;
		logic [CELLS_W-1:0]     cell_count;
		logic [THR_W-1:0]       low_threshold_pct;
		logic [THR_W-1:0]       critical_threshold_pct;
		logic [THR_W-1:0]       hysteresis_pct;
	} bcg_cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic cap;
		logic set_unknown;
		logic div1_start;
		logic div_step;
		logic eval;
		logic srch_step;
		logic div2_start;
		logic interp;
		logic commit;
	} bcg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic known;
		logic div_last;
		logic clamp;
		logic srch_done;
		logic out_free;
	} bcg_sts_t;

	// per-cell voltage of each curve point, highest first
	function automatic logic [MV_W-1:0] curve_mv_at(input logic [IDX_W-1:0] idx);
		logic [MV_W-1:0] mv;
		case (idx)
			5'd0:    mv = 13'd4200;
			5'd1:    mv = 13'd4150;
			5'd2:    mv = 13'd4110;
			5'd3:    mv = 13'd4080;
			5'd4:    mv = 13'd4020;
			5'd5:    mv = 13'd3980;
			5'd6:    mv = 13'd3950;
			5'd7:    mv = 13'd3910;
			5'd8:    mv = 13'd3870;
			5'd9:    mv = 13'd3850;
			5'd10:   mv = 13'd3840;
			5'd11:   mv = 13'd3820;
			5'd12:   mv = 13'd3800;
			5'd13:   mv = 13'd3790;
			5'd14:   mv = 13'd3770;
			5'd15:   mv = 13'd3750;
			5'd16:   mv = 13'd3730;
			5'd17:   mv = 13'd3710;
			5'd18:   mv = 13'd3690;
			5'd19:   mv = 13'd3610;
			5'd20:   mv = 13'd3270;
			default: mv = 13'd0;
		endcase
		return mv;
	endfunction

	// charge percent of each curve point
	function automatic logic [PCT_W-1:0] curve_pct_at(input logic [IDX_W-1:0] idx);
		logic [PCT_W-1:0] pct;
		case (idx)
			5'd0:    pct = 7'd100;
			5'd1:    pct = 7'd95;
			5'd2:    pct = 7'd90;
			5'd3:    pct = 7'd85;
			5'd4:    pct = 7'd80;
			5'd5:    pct = 7'd75;
			5'd6:    pct = 7'd70;
			5'd7:    pct = 7'd65;
			5'd8:    pct = 7'd60;
			5'd9:    pct = 7'd55;
			5'd10:   pct = 7'd50;
			5'd11:   pct = 7'd45;
			5'd12:   pct = 7'd40;
			5'd13:   pct = 7'd35;
			5'd14:   pct = 7'd30;
			5'd15:   pct = 7'd25;
			5'd16:   pct = 7'd20;
			5'd17:   pct = 7'd15;
			5'd18:   pct = 7'd10;
			5'd19:   pct = 7'd5;
			5'd20:   pct = 7'd0;
			default: pct = 7'd0;
		endcase
		return pct;
	endfunction

endpackage

>>> design/bcg_regs.sv
// configuration registers and latch clear pulse
`timescale 1ns / 1ps
module bcg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bcg_pkg::CFG_DATA_W-1:0] cfg_data,
	output bcg_pkg::bcg_cfg_t              cfg,
	output logic                           lat_clr
);
	import bcg_pkg::*;

	bcg_cfg_t cfg_q;
	logic     wr;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_enabled        <= 1'b0;
			cfg_q.cell_count             <= '0;
			cfg_q.low_threshold_pct      <= RST_LOW_THRESHOLD;
			cfg_q.critical_threshold_pct <= RST_CRIT_THRESHOLD;
			cfg_q.hysteresis_pct         <= RST_HYSTERESIS;
		end else if (wr) begin
			case (cfg_index)
				REG_BATTERY_ENABLED: cfg_q.battery_enabled        <= cfg_data[0];
				REG_CELL_COUNT:      cfg_q.cell_count             <= cfg_data[CELLS_W-1:0];
				REG_LOW_THRESHOLD:   cfg_q.low_threshold_pct      <= cfg_data[THR_W-1:0];
				REG_CRIT_THRESHOLD:  cfg_q.critical_threshold_pct <= cfg_data[THR_W-1:0];
				REG_HYSTERESIS:      cfg_q.hysteresis_pct         <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// battery register writes re-arm both events, hysteresis does not
	always_comb begin
		lat_clr = 1'b0;
		if (wr) begin
			case (cfg_index)
				REG_BATTERY_ENABLED,
				REG_CELL_COUNT,
				REG_LOW_THRESHOLD,
				REG_CRIT_THRESHOLD: lat_clr = 1'b1;
				default:            lat_clr = 1'b0;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/bcg_ctrl.sv
// sequencing state machine of the battery charge gauge
`timescale 1ns / 1ps
`include "battery_charge_gauge_assert.svh"
module bcg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bcg_pkg::bcg_sts_t sts,
	output bcg_pkg::bcg_cmd_t cmd
);
	import bcg_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_DIV1   = 3'd2;
	localparam logic [2:0] S_EVAL   = 3'd3;
	localparam logic [2:0] S_SRCH   = 3'd4;
	localparam logic [2:0] S_DIV2   = 3'd5;
	localparam logic [2:0] S_INTERP = 3'd6;
	localparam logic [2:0] S_COMMIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// one transaction in flight at a time
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.known) begin
					cmd.div1_start = 1'b1;
					state_d        = S_DIV1;
				end else begin
					cmd.set_unknown = 1'b1;
					state_d         = S_COMMIT;
				end
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.clamp ? S_COMMIT : S_SRCH;
			end
			S_SRCH: begin
				if (sts.srch_done) begin
					cmd.div2_start = 1'b1;
					state_d        = S_DIV2;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_INTERP;
				end
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	`BCG_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "result written over a pending one")
	`BCG_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_q == S_CHECK, "accept not followed by check")

endmodule

>>> design/bcg_dp.sv
// datapath: shared divider, curve search, interpolation, event latches, output register
`timescale 1ns / 1ps
`include "battery_charge_gauge_assert.svh"
module bcg_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bcg_pkg::bcg_cmd_t                cmd,
	output bcg_pkg::bcg_sts_t                sts,
	input  bcg_pkg::bcg_cfg_t                cfg,
	input  logic                             lat_clr,
	input  logic [bcg_pkg::VOLTAGE_BITS-1:0] pack_mv,
	input  logic                             reading_valid,
	input  logic                             on_battery,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bcg_pkg::CHARGE_W-1:0]     charge_pct,
	output logic                             critical_event,
	output logic                             low_event
);
	import bcg_pkg::*;

	// captured transaction
	logic [VOLTAGE_BITS-1:0] mv_q;
	logic                    rd_valid_q;
	logic                    on_bat_q;
	logic                    known_q;

	// shared restoring divider
	logic [SPAN_W-1:0]       rem_q;
	logic [SPAN_W-1:0]       dsr_q;
	logic [VOLTAGE_BITS-1:0] quo_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [SPAN_W:0]         trial;
	logic [SPAN_W:0]         trial_sub;
	logic                    fits;

	// curve search
	logic [IDX_W-1:0]        lo_q;
	logic [IDX_W-1:0]        hi_q;
	logic [IDX_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid;
	logic [CMP_W-1:0]        cell_cmp;
	logic                    clamp_hi;
	logic                    clamp_lo;

	// interpolation operands
	logic [CMP_W-1:0]        diff_full;
	logic [SPAN_W-1:0]       diff;
	logic [NUMER_W-1:0]      numer;
	logic [MV_W-1:0]         span_full;

	// charge and latches
	logic [CHARGE_W-1:0]     charge_q;
	logic [PCT_W-1:0]        pct;
	logic                    crit_latch_q;
	logic                    low_latch_q;
	logic                    crit_fire;
	logic                    low_fire;
	logic                    crit_rearm;
	logic                    low_rearm;

	// output register
	logic                    out_valid_q;
	logic [CHARGE_W-1:0]     charge_pct_q;
	logic                    crit_ev_q;
	logic                    low_ev_q;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mv_q       <= pack_mv;
			rd_valid_q <= reading_valid;
			on_bat_q   <= on_battery;
		end
	end

	// one quotient bit per step
	assign trial     = {rem_q, quo_q[VOLTAGE_BITS-1]};
	assign fits      = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};

	// search midpoint and bounds on the per-cell voltage
	assign cell_cmp = CMP_W'(quo_q);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IDX_W:1];
	assign clamp_hi = cell_cmp >= CMP_W'(curve_mv_at(IDX_W'(0)));
	assign clamp_lo = cell_cmp <= CMP_W'(curve_mv_at(IDX_W'(CURVE_POINTS - 1)));

	// offset into the segment times the five-percent step, and segment width
	assign diff_full = cell_cmp - CMP_W'(curve_mv_at(lo_q));
	assign diff      = diff_full[SPAN_W-1:0];
	assign numer     = (NUMER_W'(diff) << 2) + NUMER_W'(diff);
	assign span_full = curve_mv_at(lo_q - IDX_W'(1)) - curve_mv_at(lo_q);

	// divider, search and charge registers
	always_ff @(posedge clk) begin
		if (cmd.div1_start) begin
			rem_q <= '0;
			dsr_q <= SPAN_W'(cfg.cell_count);
			quo_q <= mv_q;
			cnt_q <= DIV_CNT_W'(VOLTAGE_BITS - 1);
		end else if (cmd.div2_start) begin
			rem_q <= '0;
			dsr_q <= span_full[SPAN_W-1:0];
			quo_q <= VOLTAGE_BITS'(numer);
			cnt_q <= DIV_CNT_W'(VOLTAGE_BITS - 1);
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
			quo_q <= {quo_q[VOLTAGE_BITS-2:0], fits};
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.eval) begin
			lo_q <= IDX_W'(1);
			hi_q <= IDX_W'(CURVE_POINTS - 1);
		end else if (cmd.srch_step) begin
			if (cell_cmp >= CMP_W'(curve_mv_at(mid))) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + IDX_W'(1);
			end
		end
		if (cmd.set_unknown) begin
			charge_q <= CHARGE_UNKNOWN;
			known_q  <= 1'b0;
		end else if (cmd.div1_start) begin
			known_q  <= 1'b1;
		end else if (cmd.eval) begin
			charge_q <= CHARGE_W'(clamp_hi ? PCT_FULL : PCT_EMPTY);
		end else if (cmd.interp) begin
			charge_q <= CHARGE_W'(curve_pct_at(lo_q)) + CHARGE_W'(quo_q[FRAC_W-1:0]);
		end
	end

	// latch decisions, critical and low see the same charge
	assign pct        = charge_q[PCT_W-1:0];
	assign crit_fire  = !crit_latch_q && (pct <= cfg.critical_threshold_pct);
	assign low_fire   = !low_latch_q && (pct <= cfg.low_threshold_pct);
	assign crit_rearm = crit_latch_q && ({1'b0, pct} >=
		{1'b0, cfg.critical_threshold_pct} + {1'b0, cfg.hysteresis_pct});
	assign low_rearm  = low_latch_q && ({1'b0, pct} >=
		{1'b0, cfg.low_threshold_pct} + {1'b0, cfg.hysteresis_pct});

	// event latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_latch_q <= 1'b0;
			low_latch_q  <= 1'b0;
		end else if (lat_clr) begin
			crit_latch_q <= 1'b0;
			low_latch_q  <= 1'b0;
		end else if (cmd.commit && known_q) begin
			if (crit_fire) begin
				crit_latch_q <= 1'b1;
			end else if (crit_rearm) begin
				crit_latch_q <= 1'b0;
			end
			if (low_fire) begin
				low_latch_q <= 1'b1;
			end else if (low_rearm) begin
				low_latch_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			charge_pct_q <= charge_q;
			crit_ev_q    <= known_q && crit_fire;
			low_ev_q     <= known_q && low_fire;
		end
	end

	assign out_valid      = out_valid_q;
	assign charge_pct     = charge_pct_q;
	assign critical_event = crit_ev_q;
	assign low_event      = low_ev_q;

	// status to the controller
	assign sts.known     = on_bat_q && rd_valid_q && cfg.battery_enabled &&
		(cfg.cell_count != '0);
	assign sts.div_last  = (cnt_q == '0);
	assign sts.clamp     = clamp_hi || clamp_lo;
	assign sts.srch_done = (lo_q == hi_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// checks
	`BCG_ASSERT_NOW(a_unknown_quiet, out_valid && (charge_pct == CHARGE_UNKNOWN), !critical_event && !low_event, "event with unknown charge")
	`BCG_ASSERT_NOW(a_charge_range, out_valid, (charge_pct <= CHARGE_W'(PCT_FULL)) || (charge_pct == CHARGE_UNKNOWN), "charge out of range")
	`BCG_ASSERT_NOW(a_search_order, cmd.srch_step, lo_q < hi_q, "search bounds crossed")

endmodule

>>> design/battery_charge_gauge.sv
// top level of the battery charge gauge
`timescale 1ns / 1ps
// One transaction in gives one transaction out: the pack voltage is divided by
// the cell count, mapped through a 21-point LiPo curve with linear interpolation
// and checked against the critical and low event latches. An item whose charge is
// unknown (not on battery, disabled, zero cells, invalid reading) goes from the
// check straight to the commit and reports 255. A reading clamped at the ends of
// the curve is divided once and skips the search; any other reading runs the
// 16-step restoring divider, shared by the per-cell division and the
// interpolation, twice, with a binary search over the curve between the runs.
// Items are taken one at a time; the finished result sits in an output register,
// so the next item is accepted while it waits. Configuration writes are accepted
// in every cycle and belong only to idle periods.
module battery_charge_gauge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bcg_pkg::VOLTAGE_BITS-1:0] pack_mv,
	input  logic                             reading_valid,
	input  logic                             on_battery,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bcg_pkg::CHARGE_W-1:0]     charge_pct,
	output logic                             critical_event,
	output logic                             low_event,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bcg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bcg_pkg::*;

	bcg_cfg_t cfg;
	bcg_cmd_t cmd;
	bcg_sts_t sts;
	logic     lat_clr;

	// configuration registers
	bcg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.lat_clr   (lat_clr)
	);

	// controller
	bcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	bcg_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg),
		.lat_clr        (lat_clr),
		.pack_mv        (pack_mv),
		.reading_valid  (reading_valid),
		.on_battery     (on_battery),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.charge_pct     (charge_pct),
		.critical_event (critical_event),
		.low_event      (low_event)
	);

endmodule

>>> sim/battery_charge_gauge_tb.sv
// self-checking testbench for the battery charge gauge
`timescale 1ns / 1ps
module battery_charge_gauge_tb;
	import bcg_pkg::*;

	// expected content of one result transaction
	typedef struct {
		logic [CHARGE_W-1:0] charge_pct;
		logic                critical_event;
		logic                low_event;
	} gauge_result_t;

	localparam int SETTLE_CYCLES = 48;
	localparam int PHASE_ITEMS   = 95;
	localparam int PHASE_COUNT   = 10;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic [VOLTAGE_BITS-1:0] pack_mv        = '0;
	logic                    reading_valid  = 1'b0;
	logic                    on_battery     = 1'b0;
	logic                    out_stall      = 1'b0;
	logic                    cfg_valid      = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index      = REG_BATTERY_ENABLED;
	logic [CFG_DATA_W-1:0]   cfg_data       = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic [CHARGE_W-1:0]     charge_pct;
	logic                    critical_event;
	logic                    low_event;
	logic                    cfg_ready;

	// mirror of the register file and the two event latches
	logic                    mirror_enabled = 1'b0;
	logic [CELLS_W-1:0]      mirror_cells   = '0;
	logic [THR_W-1:0]        mirror_low     = RST_LOW_THRESHOLD;
	logic [THR_W-1:0]        mirror_crit    = RST_CRIT_THRESHOLD;
	logic [THR_W-1:0]        mirror_hyst    = RST_HYSTERESIS;
	logic                    crit_tripped   = 1'b0;
	logic                    low_tripped    = 1'b0;

	// discharge curve, highest voltage first
	int unsigned knee_mv [0:20] = '{4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870,
		3850, 3840, 3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3270};
	int unsigned knee_pct [0:20] = '{100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50, 45, 40,
		35, 30, 25, 20, 15, 10, 5, 0};

	gauge_result_t pending_results [$];
	gauge_result_t want;
	int            fail_count     = 0;
	bit            sender_idle    = 1'b1;
	bit            receiver_idle  = 1'b1;
	int            stall_hold     = 0;

	battery_charge_gauge i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pack_mv        (pack_mv),
		.reading_valid  (reading_valid),
		.on_battery     (on_battery),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.charge_pct     (charge_pct),
		.critical_event (critical_event),
		.low_event      (low_event),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// clock
	always #4 clk = ~clk;

	// run limit
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// per-cell voltage to percent, linear between curve points, truncating
	function automatic int unsigned curve_percent(input int unsigned cell_mv);
		int unsigned pct;
		bit          found;
		pct   = 0;
		found = 1'b0;
		if (cell_mv >= knee_mv[0]) begin
			pct = 100;
		end else if (cell_mv > knee_mv[20]) begin
			for (int i = 1; i < 21; i++) begin
				if (!found && cell_mv >= knee_mv[i]) begin
					pct = knee_pct[i] + (cell_mv - knee_mv[i]) * (knee_pct[i-1] - knee_pct[i])
						/ (knee_mv[i-1] - knee_mv[i]);
					found = 1'b1;
				end
			end
		end
		return pct;
	endfunction

	// one-shot event with re-arm at threshold plus hysteresis
	function automatic logic latch_event(input int unsigned pct, input int unsigned thr,
			input int unsigned hyst, inout logic tripped);
		latch_event = 1'b0;
		if (!tripped && pct <= thr) begin
			tripped     = 1'b1;
			latch_event = 1'b1;
		end else if (tripped && pct >= thr + hyst) begin
			tripped = 1'b0;
		end
	endfunction

	// expected result of one reading, advancing the latches
	function automatic gauge_result_t gauge_reading(input logic [VOLTAGE_BITS-1:0] mv,
			input logic valid, input logic batt);
		gauge_result_t res;
		int unsigned   pct;
		res.charge_pct     = CHARGE_UNKNOWN;
		res.critical_event = 1'b0;
		res.low_event      = 1'b0;
		if (batt && mirror_enabled && mirror_cells != 0 && valid) begin
			pct = curve_percent(int'(mv) / int'(mirror_cells));
			res.charge_pct     = pct[CHARGE_W-1:0];
			res.critical_event = latch_event(pct, 32'(mirror_crit), 32'(mirror_hyst),
				crit_tripped);
			res.low_event      = latch_event(pct, 32'(mirror_low), 32'(mirror_hyst),
				low_tripped);
		end
		return res;
	endfunction

	// random gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		if (!receiver_idle) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
			out_stall <= 1'b1;
		end else begin
			stall_hold = pick_gap();
			if (stall_hold == 0) begin
				out_stall <= 1'b0;
			end else begin
				stall_hold--;
				out_stall <= 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: charge_pct %0d critical_event %0b low_event %0b",
					charge_pct, critical_event, low_event);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (charge_pct !== want.charge_pct) begin
					$error("charge_pct expected %0d actual %0d", want.charge_pct, charge_pct);
					fail_count++;
				end
				if (critical_event !== want.critical_event) begin
					$error("critical_event expected %0b actual %0b",
						want.critical_event, critical_event);
					fail_count++;
				end
				if (low_event !== want.low_event) begin
					$error("low_event expected %0b actual %0b", want.low_event, low_event);
					fail_count++;
				end
			end
		end
	end

	// send one reading transaction, entered and left at a falling edge
	task automatic send_reading(input logic [VOLTAGE_BITS-1:0] mv, input logic valid,
			input logic batt);
		int gap_cycles;
		gap_cycles = sender_idle ? pick_gap() : 0;
		if (gap_cycles > 0) begin
			in_valid <= 1'b0;
			repeat (gap_cycles) @(negedge clk);
		end
		pack_mv       <= mv;
		reading_valid <= valid;
		on_battery    <= batt;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(gauge_reading(mv, valid, batt));
		@(negedge clk);
	endtask

	// drain all outstanding results and let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one register write transaction, only while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BATTERY_ENABLED: mirror_enabled = data[0];
			REG_CELL_COUNT:      mirror_cells   = data[CELLS_W-1:0];
			REG_LOW_THRESHOLD:   mirror_low     = data;
			REG_CRIT_THRESHOLD:  mirror_crit    = data;
			REG_HYSTERESIS:      mirror_hyst    = data;
			default: ;
		endcase
		// battery registers re-arm both events
		if (idx == REG_BATTERY_ENABLED || idx == REG_CELL_COUNT ||
				idx == REG_LOW_THRESHOLD || idx == REG_CRIT_THRESHOLD) begin
			crit_tripped = 1'b0;
			low_tripped  = 1'b0;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// write all registers in a rotated order, unused bits randomized, sometimes after a write to an unused index
	task automatic apply_settings(input logic en, input int cells, input int low,
			input int crit, input int hyst);
		int start;
		int k;
		start = $urandom_range(0, 4);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_IDX_W'(REG_HYSTERESIS + $urandom_range(1, 3)),
				CFG_DATA_W'($urandom_range(0, 127)));
		for (int n = 0; n < 5; n++) begin
			k = (start + n) % 5;
			case (k)
				0: write_reg(REG_BATTERY_ENABLED,
					CFG_DATA_W'(($urandom_range(0, 127) & 7'h7E) | en));
				1: write_reg(REG_CELL_COUNT,
					CFG_DATA_W'(($urandom_range(0, 7) << CELLS_W) | cells));
				2: write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'(low));
				3: write_reg(REG_CRIT_THRESHOLD, CFG_DATA_W'(crit));
				default: write_reg(REG_HYSTERESIS, CFG_DATA_W'(hyst));
			endcase
		end
	endtask

	// charge unknown: disabled, zero cells, off battery, invalid reading
	task automatic test_unknown_charge();
		send_reading(16'd3900, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_BATTERY_ENABLED, 7'd1);
		send_reading(16'd3900, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_CELL_COUNT, 7'd1);
		send_reading(16'd3900, 1'b1, 1'b0);
		send_reading(16'd3900, 1'b0, 1'b1);
		send_reading(16'd3900, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_BATTERY_ENABLED, 7'd0);
		send_reading(16'd3900, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_BATTERY_ENABLED, 7'd1);
	endtask

	// curve ends, clamping and the largest division
	task automatic test_curve_ends();
		send_reading(16'hFFFF, 1'b1, 1'b1);
		send_reading(16'd4200, 1'b1, 1'b1);
		send_reading(16'd4199, 1'b1, 1'b1);
		send_reading(16'd3840, 1'b1, 1'b1);
		send_reading(16'd3271, 1'b1, 1'b1);
		send_reading(16'd3270, 1'b1, 1'b1);
		send_reading(16'd0, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_CELL_COUNT, 7'd15);
		send_reading(16'hFFFF, 1'b1, 1'b1);
		send_reading(16'd0, 1'b1, 1'b1);
		send_reading(16'd57689, 1'b1, 1'b1);
		wait_idle();
	endtask

	// event latches: firing, re-arm, both at once, clearing rules, extreme thresholds
	task automatic test_event_latches();
		write_reg(REG_CELL_COUNT, 7'd1);
		write_reg(REG_LOW_THRESHOLD, 7'd50);
		write_reg(REG_CRIT_THRESHOLD, 7'd30);
		write_reg(REG_HYSTERESIS, 7'd10);
		send_reading(16'd3840, 1'b1, 1'b1);
		send_reading(16'd3840, 1'b1, 1'b1);
		send_reading(16'd3750, 1'b1, 1'b1);
		send_reading(16'd3950, 1'b1, 1'b1);
		send_reading(16'd3270, 1'b1, 1'b1);
		wait_idle();
		// hysteresis and unused index leave the latches alone
		write_reg(REG_HYSTERESIS, 7'd0);
		send_reading(16'd3270, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_HYSTERESIS + 3'd1, 7'd0);
		send_reading(16'd3270, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_CRIT_THRESHOLD, 7'd0);
		send_reading(16'd3270, 1'b1, 1'b1);
		wait_idle();
		// threshold above 100 fires at full charge, re-arm level out of reach
		write_reg(REG_LOW_THRESHOLD, 7'd127);
		write_reg(REG_HYSTERESIS, 7'd127);
		send_reading(16'd4200, 1'b1, 1'b1);
		send_reading(16'd4200, 1'b1, 1'b1);
		wait_idle();
	endtask

	// random phases: drifting cell voltage with noise and unknown readings
	task automatic test_random_phases();
		int          cells;
		int          r;
		int          drift;
		int          cell_mv;
		int          mv;
		logic        en;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			sender_idle   = (p % 3) != 0;
			receiver_idle = (p % 4) != 1;
			case (p)
				0: apply_settings(1'b1, 1, 2, 1, 0);
				1: apply_settings(1'b1, 15, 100, 99, 100);
				2: apply_settings(1'b1, $urandom_range(1, 15), 127, 0, 127);
				default: begin
					en    = ($urandom_range(0, 9) != 0);
					cells = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 15);
					apply_settings(en, cells,
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 100),
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 60),
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20));
				end
			endcase
			cells   = (mirror_cells == 0) ? 1 : mirror_cells;
			cell_mv = $urandom_range(3250, 4250);
			drift   = $urandom_range(0, 1) ? 1 : -1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// slow discharge and recharge sweeps across the curve
					if ($urandom_range(0, 19) == 0)
						drift = -drift;
					cell_mv = cell_mv + drift * $urandom_range(0, 40);
					if (cell_mv < 3200) begin
						cell_mv = 3200;
						drift   = 1;
					end
					if (cell_mv > 4300) begin
						cell_mv = 4300;
						drift   = -1;
					end
					mv = cell_mv * cells + $urandom_range(0, cells - 1);
					if (mv > 65535)
						mv = 65535;
					send_reading(VOLTAGE_BITS'(mv), 1'b1, 1'b1);
				end else if (r < 90) begin
					send_reading(VOLTAGE_BITS'($urandom_range(0, 65535)), 1'b1, 1'b1);
				end else begin
					send_reading(VOLTAGE_BITS'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
			wait_idle();
		end
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
	endtask

	// reset, tests in turn, final verdict
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_unknown_charge();
		test_curve_ends();
		test_event_latches();
		test_random_phases();
		wait_idle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
